>>> rtl/dplb_pkg.sv
// ----------------------------------------------------------------------------
// Lorentz boost core package
// Shared beat types, unit opcodes, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
package dplb_pkg;

   localparam int unsigned MOM_WIDTH = 32;
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned DIR_BITS  = 30;

   // Largest magnitude an intermediate term may take.
   localparam logic [61:0] TERM_CAP = 62'(1) << 61;

   localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (MOM_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MASSLESS = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   localparam logic CMD_PARENT   = 1'b0;
   localparam logic CMD_DAUGHTER = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [31:0] mass;
      logic [31:0] mom_x;
      logic [31:0] mom_y;
      logic [31:0] mom_z;
   } req_type;

   typedef struct packed {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } unit_ctl_type;

   // Right shift of a wide product, capped at TERM_CAP.
   function automatic logic [61:0] shr_cap(input logic [127:0] v, input int unsigned s);
      logic [127:0] t;
      t = v >> s;
      if (t > 128'(TERM_CAP)) begin
         return TERM_CAP;
      end
      return t[61:0];
   endfunction

endpackage

>>> rtl/dplb_unit.sv
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Multiplies 64x64 eight bits a step, divides and takes square roots one
// result bit a step.
// ----------------------------------------------------------------------------
module dplb_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  dplb_pkg::unit_ctl_type ctl_i,
   input  logic [127:0]          src_x,
   input  logic [63:0]           src_y,
   output logic                  done_o,
   output logic [127:0]          acc_o,
   output logic [63:0]           quo_o
);
   import dplb_pkg::*;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [1:0]   op_ff, op_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [127:0] x_ff, x_in;
   logic [63:0]  y_ff, y_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  q_ff, q_in;

   logic [71:0]  pp;
   logic [64:0]  rem65;
   logic [67:0]  rem68;
   logic [67:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      pp      = 72'(y_ff) * 72'(x_ff[127:120]);
      rem65   = {acc_ff[63:0], x_ff[127]};
      rem68   = {acc_ff[65:0], x_ff[127:126]};
      trial   = {2'b00, q_ff, 2'b01};
      if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               acc_in = (acc_ff << 8) + 128'(pp);
               x_in   = x_ff << 8;
            end
            OP_DIV: begin
               if (rem65 >= {1'b0, y_ff}) begin
                  acc_in = 128'(64'(rem65 - {1'b0, y_ff}));
                  q_in   = {q_ff[62:0], 1'b1};
               end else begin
                  acc_in = 128'(rem65[63:0]);
                  q_in   = {q_ff[62:0], 1'b0};
               end
               x_in = x_ff << 1;
            end
            OP_SQRT: begin
               if (rem68 >= trial) begin
                  acc_in = 128'(66'(rem68 - trial));
                  q_in   = {q_ff[62:0], 1'b1};
               end else begin
                  acc_in = 128'(rem68[65:0]);
                  q_in   = {q_ff[62:0], 1'b0};
               end
               x_in = x_ff << 2;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl_i.start) begin
         busy_in = 1'b1;
         op_in   = ctl_i.op;
         acc_in  = '0;
         q_in    = '0;
         y_in    = src_y;
         x_in    = (ctl_i.op == OP_SQRT) ? src_x : {src_x[63:0], 64'd0};
         cnt_in  = (ctl_i.op == OP_MUL) ? 6'd7 : 6'd63;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
   end

   assign done_o = done_ff;
   assign acc_o  = acc_ff;
   assign quo_o  = q_ff;

endmodule

>>> rtl/decay_product_lorentz_boost_core.sv
// ----------------------------------------------------------------------------
// Lorentz boost core
// Stores a boost from a parent beat and boosts daughter momenta to the lab.
// ----------------------------------------------------------------------------
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   dplb_pkg::req_type
//   rsp_      out         rsp_valid / rsp_stall   dplb_pkg::rsp_type
//
// Every multiply, divide and square root of a beat runs in the shared
// unit, one operation at a time.
// Reset clears the stored boost; a daughter then passes unchanged.
// A finished result waits in the output register while the next beat is
// taken; only a result that finds that register still stalled waits.
// ----------------------------------------------------------------------------
module decay_product_lorentz_boost_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dplb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dplb_pkg::rsp_type rsp_data
);
   import dplb_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_P2   = 4'd1;
   localparam logic [3:0] ST_PL   = 4'd2;
   localparam logic [3:0] ST_SH   = 4'd3;
   localparam logic [3:0] ST_DIR  = 4'd4;
   localparam logic [3:0] ST_MM   = 4'd5;
   localparam logic [3:0] ST_E    = 4'd6;
   localparam logic [3:0] ST_T1   = 4'd7;
   localparam logic [3:0] ST_SS   = 4'd8;
   localparam logic [3:0] ST_CM   = 4'd9;
   localparam logic [3:0] ST_DOT  = 4'd10;
   localparam logic [3:0] ST_T2   = 4'd11;
   localparam logic [3:0] ST_OUT  = 4'd12;
   localparam logic [3:0] ST_DONE = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic        issued_ff, issued_in;
   logic        cmd_ff, cmd_in;
   logic [31:0] mass_ff, mass_in;
   logic [31:0] mom_ff [3];
   logic [31:0] mom_in [3];
   logic [31:0] sinh_ff, sinh_in;
   logic [31:0] dir_ff [3];
   logic [31:0] dir_in [3];
   logic        massless_ff, massless_in;
   logic [63:0] p2_ff, p2_in;
   logic [31:0] pl_ff, pl_in;
   logic [65:0] tmp_ff, tmp_in;
   logic [32:0] e_ff, e_in;
   logic [61:0] t1_ff, t1_in;
   logic [32:0] cm1_ff, cm1_in;
   logic [63:0] dot_ff, dot_in;
   logic [63:0] f_ff, f_in;
   logic [31:0] out_ff [3];
   logic [31:0] out_in [3];
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   unit_ctl_type unit_ctl;
   logic [127:0] src_x;
   logic [63:0]  src_y;
   logic         unit_done;
   logic [127:0] unit_acc;
   logic [63:0]  unit_quo;

   logic [31:0] mom_sel, mg_sel, dir_sel, nmag_sel;
   logic [63:0] p2_sum, dot_mag, dm, fm, prod_lo;
   logic [61:0] t2_w, dlt;
   logic signed [63:0] ms, o;
   logic        fire, idx_last, op_state, neg;

   dplb_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl_i  (unit_ctl),
      .src_x  (src_x),
      .src_y  (src_y),
      .done_o (unit_done),
      .acc_o  (unit_acc),
      .quo_o  (unit_quo)
   );

   always_comb begin
      mom_sel  = mom_ff[idx_ff];
      mg_sel   = mom_sel[31] ? (32'd0 - mom_sel) : mom_sel;
      dir_sel  = dir_ff[idx_ff];
      nmag_sel = dir_sel[31] ? (32'd0 - dir_sel) : dir_sel;
      prod_lo  = unit_acc[63:0];
      p2_sum   = p2_ff + prod_lo;
      dot_mag  = dot_ff[63] ? (64'd0 - dot_ff) : dot_ff;
      dm       = dot_mag >> DIR_BITS;
      fm       = f_ff[63] ? (64'd0 - f_ff) : f_ff;
      t2_w     = shr_cap(unit_acc, FRAC_BITS);
      dlt      = shr_cap(unit_acc, DIR_BITS);
      ms       = $signed({{32{mom_sel[31]}}, mom_sel});
      neg      = (dir_sel[31] != f_ff[63]);
      o        = neg ? (ms - $signed(64'(dlt))) : (ms + $signed(64'(dlt)));
      idx_last = (idx_ff == 2'd2);
      fire     = issued_ff && unit_done;
      op_state = (state_ff != ST_IDLE) && (state_ff != ST_DONE);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      issued_in    = issued_ff;
      cmd_in       = cmd_ff;
      mass_in      = mass_ff;
      mom_in       = mom_ff;
      sinh_in      = sinh_ff;
      dir_in       = dir_ff;
      massless_in  = massless_ff;
      p2_in        = p2_ff;
      pl_in        = pl_ff;
      tmp_in       = tmp_ff;
      e_in         = e_ff;
      t1_in        = t1_ff;
      cm1_in       = cm1_ff;
      dot_in       = dot_ff;
      f_in         = f_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unit_ctl.op  = OP_MUL;
      src_x        = '0;
      src_y        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.cmd;
               mass_in   = req_data.mass;
               mom_in[0] = req_data.mom_x;
               mom_in[1] = req_data.mom_y;
               mom_in[2] = req_data.mom_z;
               idx_in    = 2'd0;
               p2_in     = '0;
               dot_in    = '0;
               status_in = STATUS_OK;
               if (req_data.cmd == CMD_PARENT) begin
                  sinh_in     = '0;
                  dir_in[0]   = '0;
                  dir_in[1]   = '0;
                  dir_in[2]   = '0;
                  massless_in = 1'b0;
                  state_in    = ST_P2;
               end else if (massless_ff) begin
                  out_in[0] = req_data.mom_x;
                  out_in[1] = req_data.mom_y;
                  out_in[2] = req_data.mom_z;
                  status_in = STATUS_MASSLESS;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_P2;
               end
            end
         end
         ST_P2: begin
            unit_ctl.op = OP_MUL;
            src_x = 128'(mg_sel);
            src_y = 64'(mg_sel);
            if (fire) begin
               p2_in = p2_sum;
               if (!idx_last) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in = 2'd0;
                  if (cmd_ff == CMD_DAUGHTER) begin
                     state_in = ST_MM;
                  end else if (p2_sum == 64'd0) begin
                     state_in = ST_IDLE;
                  end else if (mass_ff == 32'd0) begin
                     massless_in = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     state_in = ST_PL;
                  end
               end
            end
         end
         ST_PL: begin
            unit_ctl.op = OP_SQRT;
            src_x = 128'(p2_ff);
            if (fire) begin
               pl_in    = unit_quo[31:0];
               state_in = ST_SH;
            end
         end
         ST_SH: begin
            unit_ctl.op = OP_DIV;
            src_x = 128'(64'(pl_ff) << FRAC_BITS);
            src_y = 64'(mass_ff);
            if (fire) begin
               sinh_in  = (unit_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : unit_quo[31:0];
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            unit_ctl.op = OP_DIV;
            src_x = 128'(64'(mg_sel) << DIR_BITS);
            src_y = 64'(pl_ff);
            if (fire) begin
               dir_in[idx_ff] = mom_sel[31] ? (32'd0 - unit_quo[31:0]) : unit_quo[31:0];
               if (!idx_last) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in   = 2'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MM: begin
            unit_ctl.op = OP_MUL;
            src_x = 128'(mass_ff);
            src_y = 64'(mass_ff);
            if (fire) begin
               tmp_in   = 66'(prod_lo) + 66'(p2_ff);
               state_in = ST_E;
            end
         end
         ST_E: begin
            unit_ctl.op = OP_SQRT;
            src_x = 128'(tmp_ff);
            if (fire) begin
               e_in     = unit_quo[32:0];
               state_in = ST_T1;
            end
         end
         ST_T1: begin
            unit_ctl.op = OP_MUL;
            src_x = 128'(e_ff);
            src_y = 64'(sinh_ff);
            if (fire) begin
               t1_in    = shr_cap(unit_acc, FRAC_BITS);
               state_in = ST_SS;
            end
         end
         ST_SS: begin
            unit_ctl.op = OP_MUL;
            src_x = 128'(sinh_ff);
            src_y = 64'(sinh_ff);
            if (fire) begin
               tmp_in   = 66'(prod_lo) + (66'(1) << (2 * FRAC_BITS));
               state_in = ST_CM;
            end
         end
         ST_CM: begin
            unit_ctl.op = OP_SQRT;
            src_x = 128'(tmp_ff);
            if (fire) begin
               cm1_in   = 33'(unit_quo) - (33'(1) << FRAC_BITS);
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            unit_ctl.op = OP_MUL;
            src_x = 128'(mg_sel);
            src_y = 64'(nmag_sel);
            if (fire) begin
               dot_in = (mom_sel[31] ^ dir_sel[31]) ? (dot_ff - prod_lo) : (dot_ff + prod_lo);
               if (!idx_last) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in   = 2'd0;
                  state_in = ST_T2;
               end
            end
         end
         ST_T2: begin
            unit_ctl.op = OP_MUL;
            src_x = 128'(dm);
            src_y = 64'(cm1_ff);
            if (fire) begin
               f_in = dot_ff[63] ? (64'(t1_ff) - 64'(t2_w)) : (64'(t1_ff) + 64'(t2_w));
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            unit_ctl.op = OP_MUL;
            src_x = 128'(nmag_sel);
            src_y = fm;
            if (fire) begin
               if (o > OUT_MAX) begin
                  out_in[idx_ff] = OUT_MAX[31:0];
                  status_in      = STATUS_SAT;
               end else if (o < OUT_MIN) begin
                  out_in[idx_ff] = OUT_MIN[31:0];
                  status_in      = STATUS_SAT;
               end else begin
                  out_in[idx_ff] = o[31:0];
               end
               if (!idx_last) begin
                  idx_in = idx_ff + 2'd1;
               end else begin
                  idx_in   = 2'd0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.out_x  = out_ff[0];
               rsp_data_in.out_y  = out_ff[1];
               rsp_data_in.out_z  = out_ff[2];
               rsp_data_in.status = status_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Each arithmetic state launches its unit operations one at a time and waits for each.
      unit_ctl.start = op_state && !issued_ff;
      if (op_state) begin
         if (!issued_ff) begin
            issued_in = 1'b1;
         end else if (unit_done) begin
            issued_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sinh_ff      <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= '0;
         massless_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         sinh_ff      <= sinh_in;
         dir_ff       <= dir_in;
         massless_ff  <= massless_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      mass_ff     <= mass_in;
      mom_ff      <= mom_in;
      p2_ff       <= p2_in;
      pl_ff       <= pl_in;
      tmp_ff      <= tmp_in;
      e_ff        <= e_in;
      t1_ff       <= t1_in;
      cm1_ff      <= cm1_in;
      dot_ff      <= dot_in;
      f_ff        <= f_in;
      out_ff      <= out_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/dplb_checker.sv
// ----------------------------------------------------------------------------
// Lorentz boost core port checker
// Watches the core's ports over time; attached to the core by a bind.
// ----------------------------------------------------------------------------
module dplb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input dplb_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dplb_pkg::rsp_type rsp_data
);
   import dplb_pkg::*;

   // A result beat that is held back keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Every accepted beat makes the core stall the request channel in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core took no time for an accepted beat");

   // A parent beat never produces a result.
   a_parent_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_PARENT |=> !$rose(rsp_valid))
      else $error("result appeared after a parent beat");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_MASSLESS
                     || rsp_data.status == STATUS_SAT))
      else $error("undefined status code on result beat");

endmodule

bind decay_product_lorentz_boost_core dplb_checker u_dplb_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Lorentz boost core testbench
// Drives parent and daughter beats through the core with random bursts and
// output stalls, predicts every boosted momentum and compares field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dplb_pkg::*;

   localparam int NUM_RANDOM = 1030;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   decay_product_lorentz_boost_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   req_type pending_beats[$];
   rsp_type boosted_queue[$];

   // Stored boost of the last parent.
   logic [31:0] boost_sinh = '0;
   logic [31:0] boost_dir[3] = '{default: '0};
   logic        boost_massless = 1'b0;

   int errors = 0;
   int accepted = 0;
   int parents_seen = 0;
   int results_seen = 0;
   int saturated_seen = 0;
   bit stimulus_done = 0;

   function automatic logic [63:0] isqrt_floor(input logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (128'(t) * 128'(t) <= x) begin
            r = t;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] cap_shift(input logic [127:0] v, input int s);
      logic [127:0] t;
      t = v >> s;
      return (t > (128'd1 << 61)) ? (64'd1 << 61) : t[63:0];
   endfunction

   // Apply one beat to the boost state; push a result for daughter beats.
   function automatic void predict_boost(input req_type b);
      logic signed [63:0] p[3];
      logic [63:0]        mg[3];
      logic [63:0]        p2, m, pl, s, d, e, t1, t2, cm1, dm, fm, dlt;
      logic signed [63:0] n[3], dot, f, o;
      rsp_type            r;
      p[0] = {{32{b.mom_x[31]}}, b.mom_x};
      p[1] = {{32{b.mom_y[31]}}, b.mom_y};
      p[2] = {{32{b.mom_z[31]}}, b.mom_z};
      m = {32'd0, b.mass};
      p2 = '0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = p[i] < 0 ? -p[i] : p[i];
         p2 += mg[i] * mg[i];
      end
      if (b.cmd == CMD_PARENT) begin
         parents_seen++;
         boost_sinh = '0;
         boost_dir = '{default: '0};
         boost_massless = 1'b0;
         if (p2 == 0) return;
         if (m == 0) begin
            boost_massless = 1'b1;
            return;
         end
         pl = isqrt_floor(128'(p2));
         s = (pl << FRAC_BITS) / m;
         boost_sinh = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
         for (int i = 0; i < 3; i++) begin
            d = (mg[i] << DIR_BITS) / pl;
            if (p[i] < 0) d = -d;
            boost_dir[i] = d[31:0];
         end
         return;
      end
      r.out_x = b.mom_x;
      r.out_y = b.mom_y;
      r.out_z = b.mom_z;
      r.status = STATUS_MASSLESS;
      if (!boost_massless) begin
         r.status = STATUS_OK;
         s = {32'd0, boost_sinh};
         e = isqrt_floor(128'(m) * 128'(m) + 128'(p2));
         t1 = cap_shift(128'(e) * 128'(s), FRAC_BITS);
         cm1 = isqrt_floor(128'(s) * 128'(s) + (128'd1 << (2 * FRAC_BITS)))
               - (64'd1 << FRAC_BITS);
         dot = '0;
         for (int i = 0; i < 3; i++) begin
            n[i] = {{32{boost_dir[i][31]}}, boost_dir[i]};
            dot += p[i] * n[i];
         end
         dm = (dot < 0 ? -dot : dot) >> DIR_BITS;
         t2 = cap_shift(128'(dm) * 128'(cm1), FRAC_BITS);
         f = dot < 0 ? $signed(t1) - $signed(t2) : $signed(t1) + $signed(t2);
         fm = f < 0 ? -f : f;
         for (int i = 0; i < 3; i++) begin
            dlt = cap_shift(128'(n[i] < 0 ? -n[i] : n[i]) * 128'(fm), DIR_BITS);
            o = ((n[i] < 0) != (f < 0)) ? p[i] - $signed(dlt) : p[i] + $signed(dlt);
            if (o > OUT_MAX) begin
               o = OUT_MAX;
               r.status = STATUS_SAT;
            end
            if (o < OUT_MIN) begin
               o = OUT_MIN;
               r.status = STATUS_SAT;
            end
            if (i == 0) r.out_x = o[31:0];
            else if (i == 1) r.out_y = o[31:0];
            else r.out_z = o[31:0];
         end
      end
      boosted_queue.push_back(r);
   endfunction

   function automatic logic [31:0] rand_mom();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 8) - 4) << 16;
         1: return $urandom();
         2: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      endcase
   endfunction

   function automatic req_type make_beat(input logic cmd);
      req_type b;
      b.cmd = cmd;
      case ($urandom_range(0, 5))
         0: b.mass = 32'd0;
         1: b.mass = $urandom();
         2: b.mass = 32'hFFFF_FFFF;
         default: b.mass = $urandom_range(1, 200 << 16);
      endcase
      b.mom_x = rand_mom();
      b.mom_y = rand_mom();
      b.mom_z = rand_mom();
      if ($urandom_range(0, 15) == 0) begin
         b.mom_x = '0;
         b.mom_y = '0;
         b.mom_z = '0;
      end
      return b;
   endfunction

   function automatic req_type beat(input logic cmd, input logic [31:0] mass,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z);
      req_type b;
      b.cmd = cmd;
      b.mass = mass;
      b.mom_x = x;
      b.mom_y = y;
      b.mom_z = z;
      return b;
   endfunction

   initial begin
      req_type b;
      // Daughter with no parent loaded, then the special parents.
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'h0001_0000, 32'h0003_0000,
                                   32'hFFFE_0000, 32'h0000_8000));
      pending_beats.push_back(beat(CMD_PARENT, 32'h0005_0000, 32'd0, 32'd0, 32'd0));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h0000_0001));
      pending_beats.push_back(beat(CMD_PARENT, 32'd0, 32'h0002_0000, 32'd0, 32'd0));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'd0));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'h0001_0000, 32'h0001_0000, 32'd0,
                                   32'd0));
      pending_beats.push_back(beat(CMD_PARENT, 32'h0001_0000, 32'h0000_0000,
                                   32'h0000_0000, 32'h0003_0000));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'h0001_0000, 32'd0, 32'd0,
                                   32'h0001_0000));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'd0, 32'hFFFF_0000, 32'h0002_0000,
                                   32'hFFFD_0000));
      // Huge boost: tiny mass, largest momenta; drives saturation.
      pending_beats.push_back(beat(CMD_PARENT, 32'h0000_0001, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 32'h8000_0000));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'h0001_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'd0, 32'd0, 32'd0, 32'd0));
      pending_beats.push_back(beat(CMD_PARENT, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h0000_0001, 32'hFFFF_FFFF));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'h0002_0000, 32'hFFFF_FFFF,
                                   32'h0000_0001, 32'h0001_0000));
      pending_beats.push_back(beat(CMD_PARENT, 32'h0001_0000, 32'hFFFF_0000,
                                   32'h0001_0000, 32'hFFFF_0000));
      pending_beats.push_back(beat(CMD_DAUGHTER, 32'h0000_8000, 32'h0001_0000,
                                   32'hFFFF_0000, 32'h0000_0000));
      // Mostly decays: usually a parent, then one to four beats, mostly daughters.
      while (pending_beats.size() < 20 + NUM_RANDOM) begin
         if ($urandom_range(0, 3) != 0) begin
            pending_beats.push_back(make_beat(CMD_PARENT));
         end
         repeat ($urandom_range(1, 4)) begin
            b = make_beat($urandom_range(0, 7) == 0 ? CMD_PARENT : CMD_DAUGHTER);
            pending_beats.push_back(b);
         end
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Set when the beat on the bus was not taken at the last rising edge.
   logic req_stall_q = 1'b1;
   int   stall_phase = 0;

   // Driver: bursts of beats with random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            // handled at posedge; here only decide next
         end
         if (!req_valid || !req_stall_q) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_data <= pending_beats.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
               stimulus_done <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_stall_q <= !(req_valid && !req_stall);
      if (!reset && req_valid && !req_stall) begin
         accepted++;
         predict_boost(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (boosted_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type want;
            want = boosted_queue.pop_front();
            results_seen++;
            if (want.status == STATUS_SAT) saturated_seen++;
            if (want.out_x !== rsp_data.out_x)
               $display("%0t: out_x expected %h actual %h", $time, want.out_x, rsp_data.out_x);
            if (want.out_y !== rsp_data.out_y)
               $display("%0t: out_y expected %h actual %h", $time, want.out_y, rsp_data.out_y);
            if (want.out_z !== rsp_data.out_z)
               $display("%0t: out_z expected %h actual %h", $time, want.out_z, rsp_data.out_z);
            if (want.status !== rsp_data.status)
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
            if (want !== rsp_data) errors++;
         end
      end
   end

   // Receiver stall pattern: quiet stretches alternating with heavy stalling.
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 4000;
      if (stall_phase < 1500) rsp_stall <= 1'b0;
      else rsp_stall <= $urandom_range(0, 2) != 0 ? 1'b1 : ($urandom_range(0, 1) == 1);
   end

   initial begin
      wait (stimulus_done);
      wait (boosted_queue.size() == 0);
      repeat (500) @(posedge clock);
      $display("Sent %0d beats (%0d parents) and checked %0d boosted results, %0d saturated.",
               accepted, parents_seen, results_seen, saturated_seen);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Timed out after %0d results", results_seen);
      $display("Mismatches found");
      $finish;
   end

endmodule
